[src/smpf_pkg.sv]
// Shared constants, types and helpers for the seam min-cost path finder.
package smpf_pkg;

    localparam int MAX_WIDTH   = 512;
    localparam int MAX_HEIGHT  = 512;
    localparam int ENERGY_BITS = 16;
    localparam int COST_W      = 32;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT);
    localparam int PRED_AW     = ROW_W + COL_W;
    localparam int CFG_W       = 10;
    localparam int CFG_IDX_W   = 2;
    localparam int COORD_W     = 9;

    typedef logic [COST_W-1:0]      cost_t;
    typedef logic [COL_W-1:0]       col_t;
    typedef logic [ROW_W-1:0]       row_t;
    typedef logic [CFG_W-1:0]       cfg_data_t;
    typedef logic [CFG_IDX_W-1:0]   cfg_idx_t;
    typedef logic [ENERGY_BITS-1:0] energy_t;
    typedef logic [COORD_W-1:0]     coord_t;
    typedef logic [1:0]             pred_t;

    // Predecessor codes
    localparam pred_t PRED_UP_LEFT  = 2'd0;
    localparam pred_t PRED_UP       = 2'd1;
    localparam pred_t PRED_UP_RIGHT = 2'd2;

    // Opcodes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_SEAM = 1'b1;

    // Register indexes
    localparam cfg_idx_t REG_FRAME_WIDTH  = 2'd0;
    localparam cfg_idx_t REG_FRAME_HEIGHT = 2'd1;

    typedef struct packed {
        logic capture;    // input transaction taken this cycle
        logic ld_exec;    // finish a pixel load
        logic seam_emit;  // produce a seam result
        logic seam_upd;   // step the trace to the row above
    } ctrl_cmd_t;

    typedef struct packed {
        logic in_op;      // opcode of the offered transaction
        logic out_free;   // output register can take a result
        logic seam_more;  // a trace step follows the emitted result
    } ctrl_sts_t;

    // Last usable index for a dimension: 0 is taken as 1, above max as max.
    function automatic cfg_data_t dim_last(input cfg_data_t v, input int maxv);
        cfg_data_t r;
        if (v == '0)
            r = '0;
        else if (v > cfg_data_t'(maxv))
            r = cfg_data_t'(maxv - 1);
        else
            r = v - cfg_data_t'(1);
        return r;
    endfunction

endpackage

[src/smpf_if.sv]
// Valid/ready channel interfaces for pixel input and seam output.
interface smpf_in_if;
    logic                   valid;
    logic                   ready;
    logic                   opcode;
    smpf_pkg::energy_t      pixel_energy;

    modport source (output valid, output opcode, output pixel_energy, input ready);
    modport sink   (input valid, input opcode, input pixel_energy, output ready);
endinterface

interface smpf_out_if;
    logic                   valid;
    logic                   ready;
    smpf_pkg::coord_t       seam_row;
    smpf_pkg::coord_t       seam_column;
    logic                   last_row;
    logic                   status;

    modport source (output valid, output seam_row, output seam_column, output last_row,
                    output status, input ready);
    modport sink   (input valid, input seam_row, input seam_column, input last_row,
                    input status, output ready);
endinterface

[src/smpf_datapath.sv]
// Datapath: cost line, predecessor map, trace registers and output register.
module smpf_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  smpf_pkg::cfg_idx_t    cfg_index,
    input  smpf_pkg::cfg_data_t   cfg_data,
    input  logic                  in_opcode,
    input  smpf_pkg::energy_t     in_energy,
    input  smpf_pkg::ctrl_cmd_t   cmd,
    output smpf_pkg::ctrl_sts_t   sts,
    input  logic                  out_ready,
    output logic                  out_valid,
    output smpf_pkg::coord_t      seam_row,
    output smpf_pkg::coord_t      seam_column,
    output logic                  last_row,
    output logic                  status
);

    // Memories
    smpf_pkg::cost_t cost_mem [smpf_pkg::MAX_WIDTH];
    smpf_pkg::pred_t pred_mem [smpf_pkg::MAX_WIDTH * smpf_pkg::MAX_HEIGHT];

    smpf_pkg::col_t    width_last_reg;
    smpf_pkg::row_t    height_last_reg;
    smpf_pkg::col_t    load_col_reg;
    smpf_pkg::row_t    load_row_reg;
    smpf_pkg::cost_t   left_prev_reg;
    smpf_pkg::cost_t   best_cost_reg;
    smpf_pkg::col_t    best_col_reg;
    smpf_pkg::row_t    trace_row_reg;
    smpf_pkg::col_t    trace_col_reg;
    logic              frame_ready_reg;

    smpf_pkg::energy_t energy_reg;
    smpf_pkg::col_t    x_reg;
    smpf_pkg::row_t    y_reg;
    smpf_pkg::cost_t   cost_up_reg;
    smpf_pkg::cost_t   cost_right_reg;
    smpf_pkg::pred_t   pred_rd_reg;
    smpf_pkg::col_t    emit_col_reg;

    logic              out_valid_reg;
    smpf_pkg::coord_t  seam_row_reg;
    smpf_pkg::coord_t  seam_column_reg;
    logic              last_row_reg;
    logic              status_reg;

    smpf_pkg::col_t    x_cur;
    smpf_pkg::col_t    x_right;
    smpf_pkg::row_t    y_cur;
    smpf_pkg::col_t    col_emit;
    smpf_pkg::cost_t   best_sel;
    smpf_pkg::pred_t   pick;
    logic [smpf_pkg::COST_W:0] cost_sum;
    smpf_pkg::cost_t   cost_new;
    logic              take_best;
    smpf_pkg::col_t    best_col_new;
    logic              row_end;
    logic              frame_end;
    smpf_pkg::col_t    trace_col_next;

    // Load position, clamped to the frame
    assign x_cur   = (load_col_reg > width_last_reg) ? width_last_reg : load_col_reg;
    assign y_cur   = (load_row_reg > height_last_reg) ? height_last_reg : load_row_reg;
    assign x_right = x_cur + smpf_pkg::col_t'(1);
    assign col_emit = (trace_col_reg > width_last_reg) ? width_last_reg : trace_col_reg;

    // Cost update: centre first, then left, then right on strict improvement
    always_comb
    begin
        best_sel = cost_up_reg;
        pick     = smpf_pkg::PRED_UP;
        if (x_reg != '0 && left_prev_reg < best_sel)
        begin
            best_sel = left_prev_reg;
            pick     = smpf_pkg::PRED_UP_LEFT;
        end
        if (x_reg < width_last_reg && cost_right_reg < best_sel)
        begin
            best_sel = cost_right_reg;
            pick     = smpf_pkg::PRED_UP_RIGHT;
        end
        cost_sum = {1'b0, best_sel} + (smpf_pkg::COST_W + 1)'(energy_reg);
        if (y_reg == '0)
        begin
            cost_new = smpf_pkg::cost_t'(energy_reg);
            pick     = smpf_pkg::PRED_UP;
        end
        else if (cost_sum[smpf_pkg::COST_W])
            cost_new = '1;
        else
            cost_new = cost_sum[smpf_pkg::COST_W-1:0];
    end

    assign take_best    = (y_reg == height_last_reg) && (x_reg == '0 || cost_new < best_cost_reg);
    assign best_col_new = take_best ? x_reg : best_col_reg;
    assign row_end      = (x_reg == width_last_reg);
    assign frame_end    = row_end && (y_reg == height_last_reg);

    always_comb
    begin
        trace_col_next = emit_col_reg;
        if (pred_rd_reg == smpf_pkg::PRED_UP_LEFT && emit_col_reg != '0)
            trace_col_next = emit_col_reg - smpf_pkg::col_t'(1);
        else if (pred_rd_reg == smpf_pkg::PRED_UP_RIGHT && emit_col_reg < width_last_reg)
            trace_col_next = emit_col_reg + smpf_pkg::col_t'(1);
    end

    // Cost line: two reads at capture, one write at load completion
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cost_up_reg    <= cost_mem[x_cur];
            cost_right_reg <= cost_mem[x_right];
        end
        if (cmd.ld_exec)
            cost_mem[x_reg] <= cost_new;
    end

    // Predecessor map
    always_ff @(posedge clk)
    begin
        if (cmd.ld_exec)
            pred_mem[{y_reg, x_reg}] <= pick;
        if (cmd.seam_emit)
            pred_rd_reg <= pred_mem[{trace_row_reg, col_emit}];
    end

    // Payload captures
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            energy_reg <= in_energy;
            x_reg      <= x_cur;
            y_reg      <= y_cur;
        end
        if (cmd.seam_emit)
        begin
            emit_col_reg <= col_emit;
            if (frame_ready_reg)
            begin
                seam_row_reg    <= smpf_pkg::coord_t'(trace_row_reg);
                seam_column_reg <= smpf_pkg::coord_t'(col_emit);
                last_row_reg    <= (trace_row_reg == '0);
                status_reg      <= 1'b0;
            end
            else
            begin
                seam_row_reg    <= '0;
                seam_column_reg <= '0;
                last_row_reg    <= 1'b0;
                status_reg      <= 1'b1;
            end
        end
    end

    // Frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_last_reg  <= smpf_pkg::col_t'(smpf_pkg::MAX_WIDTH - 1);
            height_last_reg <= smpf_pkg::row_t'(smpf_pkg::MAX_HEIGHT - 1);
            load_col_reg    <= '0;
            load_row_reg    <= '0;
            left_prev_reg   <= '0;
            best_cost_reg   <= '1;
            best_col_reg    <= '0;
            trace_row_reg   <= '0;
            trace_col_reg   <= '0;
            frame_ready_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.seam_emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            if (cmd.ld_exec)
            begin
                left_prev_reg <= cost_up_reg;
                if (take_best)
                begin
                    best_cost_reg <= cost_new;
                    best_col_reg  <= x_reg;
                end
                // a 1x1 frame starts and ends on the same pixel
                if (x_reg == '0 && y_reg == '0 && !frame_end)
                    frame_ready_reg <= 1'b0;
                if (!row_end)
                begin
                    load_col_reg <= x_reg + smpf_pkg::col_t'(1);
                    load_row_reg <= y_reg;
                end
                else
                begin
                    load_col_reg <= '0;
                    if (!frame_end)
                        load_row_reg <= y_reg + smpf_pkg::row_t'(1);
                    else
                    begin
                        load_row_reg    <= '0;
                        trace_row_reg   <= height_last_reg;
                        trace_col_reg   <= best_col_new;
                        frame_ready_reg <= 1'b1;
                    end
                end
            end

            if (cmd.seam_emit && frame_ready_reg && trace_row_reg == '0)
                frame_ready_reg <= 1'b0;

            if (cmd.seam_upd)
            begin
                trace_col_reg <= trace_col_next;
                trace_row_reg <= trace_row_reg - smpf_pkg::row_t'(1);
            end

            if (cfg_we && (cfg_index == smpf_pkg::REG_FRAME_WIDTH ||
                           cfg_index == smpf_pkg::REG_FRAME_HEIGHT))
            begin
                if (cfg_index == smpf_pkg::REG_FRAME_WIDTH)
                    width_last_reg <= smpf_pkg::col_t'(
                        smpf_pkg::dim_last(cfg_data, smpf_pkg::MAX_WIDTH));
                else
                    height_last_reg <= smpf_pkg::row_t'(
                        smpf_pkg::dim_last(cfg_data, smpf_pkg::MAX_HEIGHT));
                load_col_reg    <= '0;
                load_row_reg    <= '0;
                frame_ready_reg <= 1'b0;
            end
        end
    end

    assign sts.in_op     = in_opcode;
    assign sts.out_free  = !out_valid_reg || out_ready;
    assign sts.seam_more = frame_ready_reg && (trace_row_reg != '0);

    assign out_valid   = out_valid_reg;
    assign seam_row    = seam_row_reg;
    assign seam_column = seam_column_reg;
    assign last_row    = last_row_reg;
    assign status      = status_reg;

endmodule

[src/smpf_controller.sv]
// Controller: sequences pixel loads and seam trace steps.
module smpf_controller (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  smpf_pkg::ctrl_sts_t   sts,
    output smpf_pkg::ctrl_cmd_t   cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SEAM,
        ST_TRACE
    } state_t;

    state_t state_reg;
    logic   ready_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid && ready_reg)
                    begin
                        ready_reg <= 1'b0;
                        state_reg <= (sts.in_op == smpf_pkg::OP_SEAM) ? ST_SEAM : ST_LOAD;
                    end
                end
                ST_LOAD:
                begin
                    ready_reg <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                ST_SEAM:
                begin
                    if (sts.out_free)
                    begin
                        if (sts.seam_more)
                            state_reg <= ST_TRACE;
                        else
                        begin
                            ready_reg <= 1'b1;
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_TRACE:
                begin
                    ready_reg <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    ready_reg <= 1'b1;
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign in_ready      = ready_reg;
    assign cmd.capture   = in_valid && ready_reg;
    assign cmd.ld_exec   = (state_reg == ST_LOAD);
    assign cmd.seam_emit = (state_reg == ST_SEAM) && sts.out_free;
    assign cmd.seam_upd  = (state_reg == ST_TRACE);

endmodule

[src/seam_min_cost_path_finder_unit.sv]
// Top level of the vertical seam min-cost path finder.
//
// pixel_in carries one transaction per request: opcode 0 loads the next
// pixel energy in raster order, opcode 1 asks for the next seam position.
// seam_out returns one transaction for each opcode 1 request (row, column,
// last_row on row 0, status 1 when no finished seam is pending). Loads
// return nothing.
// cfg_we/cfg_index/cfg_data write frame_width (index 0) and frame_height
// (index 1); a write restarts loading at row 0, column 0 and drops any
// pending seam.
// A load reads the cost line at acceptance, then writes the cost and
// predecessor in ST_LOAD. A seam request, once seam_out can take a result,
// registers it onto seam_out in ST_SEAM, reading the predecessor map in the
// same step; the next transaction is taken after ST_SEAM, or after ST_TRACE
// when the trace steps to the row above.
// While seam_out is stalled, a seam request waits with its result unbuilt;
// loads still complete. Reset clears control state and the frame size to
// 512 x 512; the memories are not cleared and need no sweep.
module seam_min_cost_path_finder_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    smpf_in_if.sink              pixel_in,
    smpf_out_if.source           seam_out,
    input  logic                 cfg_we,
    input  smpf_pkg::cfg_idx_t   cfg_index,
    input  smpf_pkg::cfg_data_t  cfg_data
);

    smpf_pkg::ctrl_cmd_t cmd;
    smpf_pkg::ctrl_sts_t sts;

    // Sequencer: one transaction in flight at a time
    smpf_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pixel_in.valid),
        .in_ready (pixel_in.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Cost line, predecessor map, trace state and output register
    smpf_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_opcode   (pixel_in.opcode),
        .in_energy   (pixel_in.pixel_energy),
        .cmd         (cmd),
        .sts         (sts),
        .out_ready   (seam_out.ready),
        .out_valid   (seam_out.valid),
        .seam_row    (seam_out.seam_row),
        .seam_column (seam_out.seam_column),
        .last_row    (seam_out.last_row),
        .status      (seam_out.status)
    );

endmodule

[src/smpf_checker.sv]
// Port-level checks for the seam path finder, bound to the top level.
module smpf_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input smpf_pkg::coord_t  seam_row,
    input smpf_pkg::coord_t  seam_column,
    input logic              last_row,
    input logic              status
);

    // Stalled result must hold its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(seam_row) &&
        $stable(seam_column) && $stable(last_row) && $stable(status))
        else $error("seam result changed while stalled");

    // Error result carries zero coordinates
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> seam_row == '0 && seam_column == '0 && !last_row)
        else $error("error result with nonzero fields");

    // End of seam is row 0 and valid
    a_last_row0: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_row |-> seam_row == '0 && !status)
        else $error("last_row flag on a non-zero row");

    // A valid non-final position is above row 0
    a_mid_row: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !status && !last_row |-> seam_row != '0)
        else $error("row 0 emitted without last_row");

endmodule

bind seam_min_cost_path_finder_unit smpf_checker u_smpf_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (seam_out.valid),
    .out_ready   (seam_out.ready),
    .seam_row    (seam_out.seam_row),
    .seam_column (seam_out.seam_column),
    .last_row    (seam_out.last_row),
    .status      (seam_out.status)
);

[test/tb_top.sv]
// Self-checking testbench for the seam min-cost path finder: streamed frames, traced seams.
module tb_top;

    // Idling profiles for the pixel sender and the seam receiver
    localparam int IDLE_NONE = 0;
    localparam int IDLE_SEND = 1;
    localparam int IDLE_RECV = 2;
    localparam int IDLE_BOTH = 3;

    // Index with no register behind it: a write there must change nothing
    localparam smpf_pkg::cfg_idx_t REG_UNUSED = 2'd2;

    // Margin for the block to finish its last load or seam step
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct {
        logic              op;
        smpf_pkg::energy_t energy;
    } pixel_txn_t;

    typedef struct {
        smpf_pkg::coord_t row;
        smpf_pkg::coord_t column;
        logic             last;
        logic             status;
    } seam_txn_t;

    logic clk;
    logic rst_n;
    logic                 cfg_we;
    smpf_pkg::cfg_idx_t   cfg_index;
    smpf_pkg::cfg_data_t  cfg_data;

    smpf_in_if  pixel_in();
    smpf_out_if seam_out();

    seam_min_cost_path_finder_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixel_in  (pixel_in),
        .seam_out  (seam_out),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial clk = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 0;
    end

    // ------------------------------------------------------------------
    // Testbench bookkeeping
    // ------------------------------------------------------------------
    pixel_txn_t  pixel_q[$];        // items waiting to be sent; head leaves on acceptance
    seam_txn_t   seam_expect[$];    // predicted seam results, oldest first
    int unsigned queued_items;
    int unsigned sender_idle_pct;
    int unsigned sink_stall_pct;
    int unsigned mismatch_count;
    int unsigned results_seen;
    int unsigned quiet_cycles;
    bit          pixel_taken;
    bit          seam_taken;

    // ------------------------------------------------------------------
    // Seam finder model: cost line, predecessor choices, trace state
    // ------------------------------------------------------------------
    smpf_pkg::cost_t     cum_cost [smpf_pkg::MAX_WIDTH];
    smpf_pkg::pred_t     came_from [smpf_pkg::MAX_WIDTH*smpf_pkg::MAX_HEIGHT];
    int unsigned         next_col;
    int unsigned         next_row;
    smpf_pkg::cost_t     left_above;        // old cost above the previous column
    smpf_pkg::cost_t     bottom_min_cost = '1;
    int unsigned         bottom_min_col;
    int unsigned         walk_row;
    int unsigned         walk_col;
    bit                  seam_ready;
    smpf_pkg::cfg_data_t width_reg  = smpf_pkg::cfg_data_t'(512);
    smpf_pkg::cfg_data_t height_reg = smpf_pkg::cfg_data_t'(512);

    // Size in use: zero counts as one, anything past the maximum as the maximum
    function automatic int unsigned span(smpf_pkg::cfg_data_t v, int unsigned maxv);
        if (v == '0)
            return 1;
        if (int'(v) > maxv)
            return maxv;
        return int'(v);
    endfunction

    function automatic smpf_pkg::cost_t sat_sum(smpf_pkg::cost_t a, smpf_pkg::energy_t b);
        logic [smpf_pkg::COST_W:0] s;
        s = {1'b0, a} + (smpf_pkg::COST_W + 1)'(b);
        return s[smpf_pkg::COST_W] ? '1 : s[smpf_pkg::COST_W-1:0];
    endfunction

    task automatic apply_frame_reg(smpf_pkg::cfg_idx_t idx, smpf_pkg::cfg_data_t value);
        if (idx == smpf_pkg::REG_FRAME_WIDTH)
            width_reg = value;
        else if (idx == smpf_pkg::REG_FRAME_HEIGHT)
            height_reg = value;
        else
            return;
        // any real register write restarts the frame and drops the seam
        next_col   = 0;
        next_row   = 0;
        seam_ready = 0;
    endtask

    task automatic absorb_pixel(smpf_pkg::energy_t e);
        int unsigned     w, h, x, y;
        smpf_pkg::cost_t above, best, c;
        smpf_pkg::pred_t pick;
        w = span(width_reg, smpf_pkg::MAX_WIDTH);
        h = span(height_reg, smpf_pkg::MAX_HEIGHT);
        x = next_col;
        y = next_row;
        if (x >= w) x = w - 1;
        if (y >= h) y = h - 1;
        // first pixel of a frame abandons whatever seam was pending
        if (x == 0 && y == 0) seam_ready = 0;

        above = cum_cost[x];
        pick  = smpf_pkg::PRED_UP;
        if (y == 0)
            c = smpf_pkg::cost_t'(e);
        else
        begin
            // centre first, so strict less-than lets it win ties, then the left
            best = above;
            if (x > 0 && left_above < best)
            begin
                best = left_above;
                pick = smpf_pkg::PRED_UP_LEFT;
            end
            if (x + 1 < w && cum_cost[x+1] < best)
            begin
                best = cum_cost[x+1];
                pick = smpf_pkg::PRED_UP_RIGHT;
            end
            c = sat_sum(best, e);
        end
        left_above = above;
        cum_cost[x] = c;
        came_from[y*smpf_pkg::MAX_WIDTH + x] = pick;

        // leftmost minimum along the bottom row
        if (y == h - 1 && (x == 0 || c < bottom_min_cost))
        begin
            bottom_min_cost = c;
            bottom_min_col  = x;
        end

        if (x + 1 < w)
        begin
            next_col = x + 1;
            next_row = y;
        end
        else
        begin
            next_col = 0;
            if (y + 1 < h)
                next_row = y + 1;
            else
            begin
                next_row   = 0;
                walk_row   = h - 1;
                walk_col   = bottom_min_col;
                seam_ready = 1;
            end
        end
    endtask

    task automatic step_seam(output seam_txn_t r);
        int unsigned     w, rr, col;
        smpf_pkg::pred_t code;
        r.row    = '0;
        r.column = '0;
        r.last   = 1'b0;
        r.status = 1'b1;
        if (!seam_ready)
            return;
        w   = span(width_reg, smpf_pkg::MAX_WIDTH);
        rr  = walk_row;
        col = walk_col;
        if (rr >= smpf_pkg::MAX_HEIGHT) rr = smpf_pkg::MAX_HEIGHT - 1;
        if (col >= w) col = w - 1;
        r.row    = smpf_pkg::coord_t'(rr);
        r.column = smpf_pkg::coord_t'(col);
        r.last   = (rr == 0);
        r.status = 1'b0;
        if (rr == 0)
            seam_ready = 0;
        else
        begin
            code = came_from[rr*smpf_pkg::MAX_WIDTH + col];
            if (code == smpf_pkg::PRED_UP_LEFT && col > 0)
                col = col - 1;
            else if (code == smpf_pkg::PRED_UP_RIGHT && col + 1 < w)
                col = col + 1;
            walk_col = col;
            walk_row = rr - 1;
        end
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatch_count++;
        $display("MISMATCH %s: got %0d, expected %0d (seam result %0d)",
                 what, got, want, results_seen);
    endtask

    // ------------------------------------------------------------------
    // Driver: pixel channel and seam ready change on the falling edge.
    // valid only drops or moves on after the current transaction is taken.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : pixel_driver
        if (!rst_n)
        begin
            pixel_in.valid <= 1'b0;
            seam_out.ready <= 1'b0;
        end
        else
        begin
            if (!pixel_in.valid || pixel_taken)
            begin
                if (pixel_q.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    pixel_in.valid        <= 1'b1;
                    pixel_in.opcode       <= pixel_q[0].op;
                    pixel_in.pixel_energy <= pixel_q[0].energy;
                end
                else
                    pixel_in.valid <= 1'b0;
            end
            seam_out.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: everything sampled on the rising edge. Results are checked
    // before the pixel accepted on the same edge is fed to the model; a
    // result can never belong to a request taken on that same edge.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        seam_txn_t want;
        if (rst_n)
        begin
            pixel_taken = pixel_in.valid && pixel_in.ready;
            seam_taken  = seam_out.valid && seam_out.ready;

            if (seam_taken)
            begin
                results_seen++;
                if (seam_expect.size() == 0)
                    report_mismatch("seam result with nothing expected, row",
                                    32'(seam_out.seam_row), 0);
                else
                begin
                    want = seam_expect.pop_front();
                    if (seam_out.seam_row !== want.row)
                        report_mismatch("seam_row", 32'(seam_out.seam_row), 32'(want.row));
                    if (seam_out.seam_column !== want.column)
                        report_mismatch("seam_column", 32'(seam_out.seam_column),
                                        32'(want.column));
                    if (seam_out.last_row !== want.last)
                        report_mismatch("last_row", 32'(seam_out.last_row), 32'(want.last));
                    if (seam_out.status !== want.status)
                        report_mismatch("status", 32'(seam_out.status), 32'(want.status));
                end
            end

            if (pixel_taken)
            begin
                void'(pixel_q.pop_front());
                if (pixel_in.opcode == smpf_pkg::OP_LOAD)
                    absorb_pixel(pixel_in.pixel_energy);
                else
                begin
                    step_seam(want);
                    seam_expect.push_back(want);
                end
            end

            if (cfg_we)
                apply_frame_reg(cfg_index, cfg_data);

            // watchdog: only cycles with work outstanding and no progress count
            if (pixel_taken || seam_taken || (pixel_q.size() == 0 && seam_expect.size() == 0))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic set_idling(int mode);
        case (mode)
            IDLE_SEND: begin sender_idle_pct = 67; sink_stall_pct = 0;  end
            IDLE_RECV: begin sender_idle_pct = 0;  sink_stall_pct = 67; end
            IDLE_BOTH: begin sender_idle_pct = 30; sink_stall_pct = 30; end
            default:   begin sender_idle_pct = 0;  sink_stall_pct = 0;  end
        endcase
    endtask

    task automatic push_load(smpf_pkg::energy_t e);
        pixel_txn_t t;
        t.op     = smpf_pkg::OP_LOAD;
        t.energy = e;
        pixel_q.push_back(t);
        queued_items++;
    endtask

    // energy field carries noise on seam requests; the block ignores it
    task automatic push_requests(int unsigned n);
        pixel_txn_t t;
        repeat (n)
        begin
            t.op     = smpf_pkg::OP_SEAM;
            t.energy = smpf_pkg::energy_t'($urandom);
            pixel_q.push_back(t);
            queued_items++;
        end
    endtask

    // Wait for the block to go idle: nothing left to send, every result back,
    // then a few cycles for a trailing load to finish inside the block.
    task automatic settle();
        while (pixel_q.size() != 0 || seam_expect.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Called on a falling edge with cfg_we low; returns with cfg_we low again
    task automatic write_reg(smpf_pkg::cfg_idx_t idx, smpf_pkg::cfg_data_t value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    function automatic smpf_pkg::energy_t pick_energy(int flavor);
        case (flavor)
            0:       return smpf_pkg::energy_t'($urandom_range(3));      // dense ties
            1:       return $urandom_range(1) ? {smpf_pkg::ENERGY_BITS{1'b1}}
                                              : smpf_pkg::energy_t'(0);
            2:       return smpf_pkg::energy_t'($urandom_range(255));
            default: return smpf_pkg::energy_t'($urandom);
        endcase
    endfunction

    // A size of one may also be written as zero
    function automatic smpf_pkg::cfg_data_t size_code(int unsigned dim);
        if (dim == 1 && $urandom_range(1) == 0)
            return '0;
        return smpf_pkg::cfg_data_t'(dim);
    endfunction

    // Mostly whole frames with random content, each read back in full.
    // Mixed in: partial reads, extra reads past row 0, requests before or
    // inside a frame, and truncated frames that force a size rewrite.
    task automatic random_frames(int unsigned target);
        int unsigned first, w, h, n, cut, noise_at, i;
        int          flavor;
        bit          restart;
        first   = queued_items;
        restart = 1;
        w       = 1;
        h       = 1;
        while (queued_items - first < target)
        begin
            if (restart || $urandom_range(2) == 0)
            begin
                settle();
                set_idling($urandom_range(3));
                w = ($urandom_range(7) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
                h = ($urandom_range(7) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
                write_reg(smpf_pkg::REG_FRAME_WIDTH, size_code(w));
                write_reg(smpf_pkg::REG_FRAME_HEIGHT, size_code(h));
                restart = 0;
            end
            else if ($urandom_range(9) == 0)
                settle();   // hold the sender until every result is back

            if ($urandom_range(4) == 0)
                push_requests($urandom_range(1, 2));

            n        = w * h;
            cut      = ($urandom_range(9) == 0) ? $urandom_range(0, n - 1) : n;
            noise_at = ($urandom_range(7) == 0 && n > 1) ? $urandom_range(1, n - 1) : n;
            flavor   = $urandom_range(3);
            for (i = 0; i < cut; i++)
            begin
                if (i == noise_at)
                    push_requests(1);   // mid-frame: no seam to give
                push_load(pick_energy(flavor));
            end

            if (cut != n)
            begin
                push_requests($urandom_range(1, 2));
                restart = 1;
            end
            else
            begin
                case ($urandom_range(5))
                    0:       push_requests($urandom_range(0, h - 1));
                    1:       push_requests(h + $urandom_range(1, 2));
                    default: push_requests(h);
                endcase
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int unsigned i;
        rst_n                 = 1'b0;
        pixel_in.valid        = 1'b0;
        pixel_in.opcode       = smpf_pkg::OP_LOAD;
        pixel_in.pixel_energy = '0;
        seam_out.ready        = 1'b0;
        cfg_we                = 1'b0;
        cfg_index             = smpf_pkg::REG_FRAME_WIDTH;
        cfg_data              = '0;
        set_idling(IDLE_NONE);

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        settle();

        // Directed: request with no frame loaded
        set_idling(IDLE_BOTH);
        push_requests(1);
        settle();

        // 3x3 frame: edge columns, centre-wins ties, extremes
        write_reg(smpf_pkg::REG_FRAME_WIDTH, smpf_pkg::cfg_data_t'(3));
        write_reg(smpf_pkg::REG_FRAME_HEIGHT, smpf_pkg::cfg_data_t'(3));
        push_load(smpf_pkg::energy_t'(4));
        push_load(smpf_pkg::energy_t'(2));
        push_load(smpf_pkg::energy_t'(2));
        push_load(16'hFFFF);
        push_load(smpf_pkg::energy_t'(0));
        push_load(smpf_pkg::energy_t'(7));
        push_load(smpf_pkg::energy_t'(0));
        push_load(smpf_pkg::energy_t'(3));
        push_load(smpf_pkg::energy_t'(0));
        settle();
        // no register at this index: the finished seam stays pending
        write_reg(REG_UNUSED, '1);
        push_requests(4);   // rows 2..0, then the seam is used up
        settle();

        // zero width and height act as 1x1
        write_reg(smpf_pkg::REG_FRAME_WIDTH, '0);
        write_reg(smpf_pkg::REG_FRAME_HEIGHT, '0);
        push_load(16'h8001);
        push_requests(1);
        settle();

        // 2x2: read only the bottom row, then a new frame abandons the seam
        write_reg(smpf_pkg::REG_FRAME_WIDTH, smpf_pkg::cfg_data_t'(2));
        write_reg(smpf_pkg::REG_FRAME_HEIGHT, smpf_pkg::cfg_data_t'(2));
        push_load(smpf_pkg::energy_t'(5));
        push_load(smpf_pkg::energy_t'(5));
        push_load(smpf_pkg::energy_t'(9));
        push_load(smpf_pkg::energy_t'(1));
        push_requests(1);
        push_load(smpf_pkg::energy_t'(3));
        push_load(smpf_pkg::energy_t'(1));
        push_load(smpf_pkg::energy_t'(0));
        push_load(16'hFFFF);
        push_requests(3);
        settle();

        // Height past the maximum, one column; first rows of the trace under stalls
        set_idling(IDLE_RECV);
        write_reg(smpf_pkg::REG_FRAME_WIDTH, smpf_pkg::cfg_data_t'(1));
        write_reg(smpf_pkg::REG_FRAME_HEIGHT, smpf_pkg::cfg_data_t'(1023));
        for (i = 0; i < smpf_pkg::MAX_HEIGHT; i++)
            push_load(pick_energy(3));
        push_requests(3);
        settle();

        random_frames(360);

        settle();
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

[sim.f]
src/smpf_pkg.sv
src/smpf_if.sv
src/smpf_datapath.sv
src/smpf_controller.sv
src/seam_min_cost_path_finder_unit.sv
src/smpf_checker.sv
test/tb_top.sv
